[rtl/owbm_pkg.sv]
`timescale 1ns / 1ps
// owbm_pkg: shared types and constants of the one-wire bus master.
// No dependencies.
package owbm_pkg;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam int NUM_REGS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int REG_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_REC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RST_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RST_WAIT   = 3'd5;

  localparam logic [REG_W-1:0] RST_SHORT_LOW  = 16'd2;
  localparam logic [REG_W-1:0] RST_WRITE_SLOT = 16'd60;
  localparam logic [REG_W-1:0] RST_READ_SAMP  = 16'd8;
  localparam logic [REG_W-1:0] RST_READ_REC   = 16'd60;
  localparam logic [REG_W-1:0] RST_RST_LOW    = 16'd500;
  localparam logic [REG_W-1:0] RST_RST_WAIT   = 16'd500;

  typedef struct packed {
    logic [REG_W-1:0] short_low;
    logic [REG_W-1:0] write_slot;
    logic [REG_W-1:0] read_sample;
    logic [REG_W-1:0] read_recovery;
    logic [REG_W-1:0] reset_low;
    logic [REG_W-1:0] reset_wait;
  } owbm_timing_t;

endpackage

[rtl/owbm_cfg_regs.sv]
`timescale 1ns / 1ps
// owbm_cfg_regs: phase length register file written over the config channel.
// Depends on owbm_pkg.
module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output owbm_timing_t         timing
);

  owbm_timing_t timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.short_low     <= RST_SHORT_LOW;
      timing_r.write_slot    <= RST_WRITE_SLOT;
      timing_r.read_sample   <= RST_READ_SAMP;
      timing_r.read_recovery <= RST_READ_REC;
      timing_r.reset_low     <= RST_RST_LOW;
      timing_r.reset_wait    <= RST_RST_WAIT;
    end else if (wr_en) begin
      case (wr_index)
        REG_SHORT_LOW:  timing_r.short_low     <= wr_data;
        REG_WRITE_SLOT: timing_r.write_slot    <= wr_data;
        REG_READ_SAMP:  timing_r.read_sample   <= wr_data;
        REG_READ_REC:   timing_r.read_recovery <= wr_data;
        REG_RST_LOW:    timing_r.reset_low     <= wr_data;
        REG_RST_WAIT:   timing_r.reset_wait    <= wr_data;
        default: ;
      endcase
    end
  end

  assign timing = timing_r;

endmodule

[rtl/owbm_core.sv]
`timescale 1ns / 1ps
// owbm_core: bit slot sequencer; one step per tick, results registered.
// Depends on owbm_pkg.
module owbm_core
  import owbm_pkg::*;
#(
  parameter int MAX_BITS    = 64,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          operation,
  input  logic [1:0]          width_code,
  input  logic [MAX_BITS-1:0] write_data,
  input  logic                bus_level,
  input  owbm_timing_t        timing,
  output logic                drive_enable,
  output logic                drive_level,
  output logic                busy_res,
  output logic                done_res,
  output logic [MAX_BITS-1:0] read_data,
  output logic                command_rejected
);

  localparam int CNT_W = $clog2(MAX_BITS + 1);
  localparam int POS_W = $clog2(MAX_BITS);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_W_LOW    = 3'd3,
    PH_W_HOLD   = 3'd4,
    PH_R_LOW    = 3'd5,
    PH_R_WAIT   = 3'd6,
    PH_R_REC    = 3'd7
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]       bits_left_r, bits_left_nxt;
  logic [MAX_BITS-1:0]    send_r, send_nxt;
  logic [MAX_BITS-1:0]    recv_r, recv_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  logic de_r, de_nxt;
  logic dl_r, dl_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic rej_r, rej_nxt;

  logic [7:0]             cnt8;
  logic [TIMER_WIDTH-1:0] cur_len;
  logic [TIMER_WIDTH:0]   tick_inc;

  // zero reads as one tick, values above the timer range saturate
  function automatic logic [TIMER_WIDTH-1:0] clamp_len(input logic [REG_W-1:0] v);
    logic [32:0] ext;
    logic [32:0] tmax;
    ext  = {17'd0, v};
    tmax = (33'd1 << TIMER_WIDTH) - 33'd1;
    if (ext == 33'd0) ext = 33'd1;
    if (ext > tmax) ext = tmax;
    return ext[TIMER_WIDTH-1:0];
  endfunction

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bits_left_nxt = bits_left_r;
    send_nxt      = send_r;
    recv_nxt      = recv_r;
    pos_nxt       = pos_r;
    rej_nxt       = 1'b0;
    done_nxt      = 1'b0;

    cnt8 = 8'd8 << width_code;
    if (cnt8 > 8'(MAX_BITS)) cnt8 = 8'(MAX_BITS);

    if (op_t'(operation) != OP_NONE) begin
      if (phase_r != PH_IDLE) begin
        rej_nxt = 1'b1;
      end else begin
        tick_nxt = '0;
        pos_nxt  = '0;
        case (op_t'(operation))
          OP_RESET: begin
            phase_nxt     = PH_RST_LOW;
            bits_left_nxt = '0;
          end
          OP_WRITE: begin
            phase_nxt     = PH_W_LOW;
            bits_left_nxt = cnt8[CNT_W-1:0];
            send_nxt      = write_data;
          end
          default: begin
            phase_nxt     = PH_R_LOW;
            bits_left_nxt = cnt8[CNT_W-1:0];
            recv_nxt      = '0;
          end
        endcase
      end
    end

    busy_nxt = (phase_nxt != PH_IDLE);
    case (phase_nxt) inside
      PH_RST_LOW, PH_W_LOW, PH_R_LOW: begin
        de_nxt = 1'b1;
        dl_nxt = 1'b0;
      end
      PH_W_HOLD: begin
        de_nxt = 1'b1;
        dl_nxt = send_nxt[0];
      end
      default: begin
        de_nxt = 1'b0;
        dl_nxt = 1'b1;
      end
    endcase

    if (phase_nxt == PH_R_REC && tick_nxt == '0 && bus_level)
      recv_nxt[pos_nxt] = 1'b1;

    case (phase_nxt)
      PH_RST_LOW:  cur_len = clamp_len(timing.reset_low);
      PH_RST_WAIT: cur_len = clamp_len(timing.reset_wait);
      PH_W_LOW:    cur_len = clamp_len(timing.short_low);
      PH_W_HOLD:   cur_len = clamp_len(timing.write_slot);
      PH_R_LOW:    cur_len = clamp_len(timing.short_low);
      PH_R_WAIT:   cur_len = clamp_len(timing.read_sample);
      PH_R_REC:    cur_len = clamp_len(timing.read_recovery);
      default:     cur_len = TIMER_WIDTH'(1);
    endcase

    tick_inc = {1'b0, tick_nxt} + {{TIMER_WIDTH{1'b0}}, 1'b1};

    if (busy_nxt) begin
      tick_nxt = tick_inc[TIMER_WIDTH-1:0];
      if (tick_inc >= {1'b0, cur_len}) begin
        tick_nxt = '0;
        case (phase_nxt)
          PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
          PH_RST_WAIT: begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
          PH_W_LOW:    phase_nxt = PH_W_HOLD;
          PH_R_LOW:    phase_nxt = PH_R_WAIT;
          PH_R_WAIT:   phase_nxt = PH_R_REC;
          PH_W_HOLD, PH_R_REC: begin
            send_nxt = send_nxt >> 1;
            pos_nxt  = pos_nxt + POS_W'(1);
            if (bits_left_nxt != '0) bits_left_nxt = bits_left_nxt - CNT_W'(1);
            if (bits_left_nxt == '0) begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end else if (phase_nxt == PH_W_HOLD) begin
              phase_nxt = PH_W_LOW;
            end else begin
              phase_nxt = PH_R_LOW;
            end
          end
          default:     phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bits_left_r <= '0;
      send_r      <= '0;
      recv_r      <= '0;
      pos_r       <= '0;
      de_r        <= 1'b0;
      dl_r        <= 1'b1;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      rej_r       <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bits_left_r <= bits_left_nxt;
      send_r      <= send_nxt;
      recv_r      <= recv_nxt;
      pos_r       <= pos_nxt;
      de_r        <= de_nxt;
      dl_r        <= dl_nxt;
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      rej_r       <= rej_nxt;
    end
  end

  assign drive_enable     = de_r;
  assign drive_level      = dl_r;
  assign busy_res         = busy_r;
  assign done_res         = done_r;
  assign read_data        = recv_r;
  assign command_rejected = rej_r;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> busy_r) else $error("done without busy");

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rej_r |-> busy_r) else $error("reject while idle");

  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    !de_r |-> dl_r) else $error("released line not reported high");

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == '0) else $error("timer running while idle");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done_nxt) |=> phase_r == PH_IDLE) else $error("done but still active");

endmodule

[rtl/one_wire_bus_master.sv]
`timescale 1ns / 1ps
// one_wire_bus_master: top level; input register, handshakes, config port.
// Depends on owbm_pkg, owbm_cfg_regs, owbm_core.
//
// One-wire bus master stepped by one input transfer per bus tick. Each input
// transfer yields exactly one result transfer; a new item is taken every cycle
// while the result side keeps up, and the matching result passes through one
// input register and one result register. Phase lengths, in ticks, come from
// six 16-bit registers written over the cfg_ channel, which is always ready;
// write them only while no command is running.
// Commands issued while a command is running are dropped and flagged.
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int MAX_BITS    = 64,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_operation,
  input  logic [1:0]           in_width_code,
  input  logic [MAX_BITS-1:0]  in_write_data,
  input  logic                 in_bus_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_drive_enable,
  output logic                 out_drive_level,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [MAX_BITS-1:0]  out_read_data,
  output logic                 out_command_rejected,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic                in_v_r;
  logic                out_v_r;
  logic [1:0]          op_r;
  logic [1:0]          wc_r;
  logic [MAX_BITS-1:0] wdata_r;
  logic                bus_r;
  logic                out_free;
  logic                fire;
  logic                in_take;
  owbm_timing_t        timing;

  assign out_free = !out_v_r || !out_stall;
  assign fire     = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_v_r || fire) in_v_r <= in_valid;
      if (out_free) out_v_r <= fire;
    end
    if (in_take) begin
      op_r    <= in_operation;
      wc_r    <= in_width_code;
      wdata_r <= in_write_data;
      bus_r   <= in_bus_level;
    end
  end

  assign out_valid = out_v_r;
  assign cfg_ready = 1'b1;

  owbm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .timing   (timing)
  );

  owbm_core #(
    .MAX_BITS    (MAX_BITS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (fire),
    .operation        (op_r),
    .width_code       (wc_r),
    .write_data       (wdata_r),
    .bus_level        (bus_r),
    .timing           (timing),
    .drive_enable     (out_drive_enable),
    .drive_level      (out_drive_level),
    .busy_res         (out_busy_res),
    .done_res         (out_done_res),
    .read_data        (out_read_data),
    .command_rejected (out_command_rejected)
  );

endmodule
